FILE: rtl/vspd_pkg.sv
// ----------------------------------------------------------------------------
// vspd_pkg: shared constants of the volume slice pair downsampler
// Register indexes, configuration widths and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package vspd_pkg;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 11;

  // Width of the slice_width / slice_height registers
  localparam int DIM_CFG_W = 11;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_METHOD       = 3'd0,
    CFG_IS_SIGNED    = 3'd1,
    CFG_VOXEL_WIDTH  = 3'd2,
    CFG_SLICE_WIDTH  = 3'd3,
    CFG_SLICE_HEIGHT = 3'd4
  } cfg_index_t;

  // Reduction methods
  localparam logic METHOD_MAX = 1'b0;
  localparam logic METHOD_AVG = 1'b1;

  // Reset value of both slice dimensions
  localparam logic [DIM_CFG_W-1:0] DIM_RESET = 11'd1024;

  // Parameter defaults
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int VOXEL_BITS_DEF = 16;

  // Narrow voxel mode width
  localparam int NARROW_BITS = 8;

endpackage

`default_nettype wire

FILE: rtl/volume_slice_pair_downsample_top.sv
// ----------------------------------------------------------------------------
// volume_slice_pair_downsample_top: 2x2x2 max / average pooling of two slices
// Streams slice A into a reduced-2x2 buffer, then combines slice B with it
// and emits one half-resolution voxel per 2x2x2 group.
// ----------------------------------------------------------------------------
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------
//   input    | in_valid / in_ready   | voxel
//   output   | out_valid / out_ready | reduced_voxel, last_of_slice
//   config   | cfg_write             | cfg_index, cfg_data
//
// One voxel is accepted per clock. A result passes through the stage 1 and
// stage 2 registers into the output register once the voxel that completes
// its group is accepted. The path runs through the row-pair buffer (stage 1
// read) and the slice-A buffer (stage 2 read), each a memory with one read
// and one write per cycle and a registered read.
// The input stalls only when a result reaches the last stage while the output
// register is still held. No clearing pass after reset: both buffers are
// always written before they are read.
// ----------------------------------------------------------------------------
`default_nettype none

module volume_slice_pair_downsample_top #(
  parameter int MAX_WIDTH  = vspd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = vspd_pkg::MAX_HEIGHT_DEF,
  parameter int VOXEL_BITS = vspd_pkg::VOXEL_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration
  input  wire logic                            cfg_write,
  input  wire logic [vspd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [vspd_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input voxels
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [VOXEL_BITS-1:0]           voxel,
  // reduced voxels
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [VOXEL_BITS-1:0]                reduced_voxel,
  output logic                                 last_of_slice
);

  localparam int DW      = VOXEL_BITS + 1;
  localparam int HALF_W  = (MAX_WIDTH + 1) / 2;
  localparam int HALF_H  = (MAX_HEIGHT + 1) / 2;
  localparam int SA_DEPTH = HALF_W * HALF_H;
  localparam int CW      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW      = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int XW      = (HALF_W > 1) ? $clog2(HALF_W) : 1;
  localparam int AW      = (SA_DEPTH > 1) ? $clog2(SA_DEPTH) : 1;
  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_W   = ($clog2(MAX_DIM + 1) > vspd_pkg::DIM_CFG_W) ?
                           $clog2(MAX_DIM + 1) : vspd_pkg::DIM_CFG_W;

  // max, or floor of the mean at full precision
  function automatic logic signed [DW-1:0] reduce2(input logic m,
                                                   input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
    logic [DW:0] s;
    begin
      s = {a[DW-1], a} + {b[DW-1], b};
      if (m == vspd_pkg::METHOD_MAX) begin
        reduce2 = (a > b) ? a : b;
      end else begin
        reduce2 = s[DW:1];
      end
    end
  endfunction

  // configuration registers
  logic                           cfg_method;
  logic                           cfg_signed;
  logic                           cfg_wide;
  logic [vspd_pkg::DIM_CFG_W-1:0] cfg_width;
  logic [vspd_pkg::DIM_CFG_W-1:0] cfg_height;

  // stream position
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [AW-1:0] ybase;
  logic          phase;
  logic signed [DW-1:0] held_even;

  // memories
  logic signed [DW-1:0] rp_mem [HALF_W];
  logic signed [DW-1:0] sa_mem [SA_DEPTH];
  logic signed [DW-1:0] rp_rdata;
  logic signed [DW-1:0] sa_rdata;

  // stage 1
  logic                 v1;
  logic                 has_pair1;
  logic                 odd_row1;
  logic                 last_row1;
  logic                 phase1;
  logic                 last1;
  logic [AW-1:0]        idx1;
  logic signed [DW-1:0] pair1;

  // stage 2
  logic                 v2;
  logic                 has_vert2;
  logic                 phase2;
  logic                 last2;
  logic signed [DW-1:0] vert2;

  // stage 0 logic
  logic [DIM_W-1:0]     w_eff;
  logic [DIM_W-1:0]     h_eff;
  logic [DIM_W-1:0]     hw;
  logic                 last_col;
  logic                 last_row;
  logic                 odd_col;
  logic                 odd_row;
  logic [XW-1:0]        x0;
  logic [AW-1:0]        idx0;
  logic signed [DW-1:0] v_dec;
  logic signed [DW-1:0] pair0;
  logic                 has_pair0;
  logic                 rp_we;
  logic                 accept;
  logic                 en;
  logic                 s2_result;

  // stage 1 / 2 logic
  logic                 has_vert1;
  logic signed [DW-1:0] vert1;
  logic signed [DW-1:0] res2;
  logic [VOXEL_BITS-1:0] out_mask;

  always_comb begin
    if (cfg_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (DIM_W'(cfg_width) > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = DIM_W'(cfg_width);
    end
    if (cfg_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (DIM_W'(cfg_height) > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = DIM_W'(cfg_height);
    end
  end

  assign hw = DIM_W'(({1'b0, w_eff} + (DIM_W + 1)'(1)) >> 1);

  assign last_col = (DIM_W'(col) == w_eff - DIM_W'(1));
  assign last_row = (DIM_W'(row) == h_eff - DIM_W'(1));
  assign odd_col  = col[0];
  assign odd_row  = row[0];
  assign x0       = XW'(col >> 1);
  assign idx0     = ybase + AW'(x0);

  always_comb begin
    if (cfg_wide) begin
      v_dec = {cfg_signed & voxel[VOXEL_BITS-1], voxel};
    end else begin
      v_dec = {{(DW - vspd_pkg::NARROW_BITS){cfg_signed & voxel[vspd_pkg::NARROW_BITS-1]}},
               voxel[vspd_pkg::NARROW_BITS-1:0]};
    end
  end

  // horizontal pair: odd column closes it, an even last column pairs with zero
  assign has_pair0 = odd_col | last_col;
  assign pair0     = odd_col ? reduce2(cfg_method, held_even, v_dec)
                             : reduce2(cfg_method, v_dec, '0);

  assign s2_result = v2 & has_vert2 & phase2;
  assign en        = ~(out_valid & ~out_ready & s2_result);
  assign in_ready  = en;
  assign accept    = in_valid & en;
  assign rp_we     = accept & has_pair0 & ~odd_row & ~last_row;

  // configuration and stream position
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_method <= 1'b0;
      cfg_signed <= 1'b0;
      cfg_wide   <= 1'b0;
      cfg_width  <= vspd_pkg::DIM_RESET;
      cfg_height <= vspd_pkg::DIM_RESET;
      col        <= '0;
      row        <= '0;
      ybase      <= '0;
      phase      <= 1'b0;
      held_even  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        vspd_pkg::CFG_METHOD:       cfg_method <= cfg_data[0];
        vspd_pkg::CFG_IS_SIGNED:    cfg_signed <= cfg_data[0];
        vspd_pkg::CFG_VOXEL_WIDTH:  cfg_wide   <= cfg_data[0];
        vspd_pkg::CFG_SLICE_WIDTH:  cfg_width  <= cfg_data[vspd_pkg::DIM_CFG_W-1:0];
        vspd_pkg::CFG_SLICE_HEIGHT: cfg_height <= cfg_data[vspd_pkg::DIM_CFG_W-1:0];
        default: ;
      endcase
      // any write within the register list restarts the stream
      if (cfg_index <= vspd_pkg::CFG_SLICE_HEIGHT) begin
        col       <= '0;
        row       <= '0;
        ybase     <= '0;
        phase     <= 1'b0;
        held_even <= '0;
      end
    end else if (accept) begin
      if (!has_pair0) begin
        held_even <= v_dec;
      end
      if (last_col) begin
        col <= '0;
        if (last_row) begin
          row   <= '0;
          ybase <= '0;
          phase <= ~phase;
        end else begin
          row <= row + RW'(1);
          if (odd_row) begin
            ybase <= ybase + AW'(hw);
          end
        end
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // row-pair buffer: write in stage 0, read for stage 1
  always_ff @(posedge clk) begin
    if (rp_we) begin
      rp_mem[x0] <= pair0;
    end
    if (en) begin
      rp_rdata <= rp_mem[x0];
    end
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      has_pair1 <= has_pair0;
      odd_row1  <= odd_row;
      last_row1 <= last_row;
      phase1    <= phase;
      last1     <= last_col & last_row;
      idx1      <= idx0;
      pair1     <= pair0;
    end
  end

  // vertical pair: odd row closes it, an even last row pairs with zero
  assign has_vert1 = has_pair1 & (odd_row1 | last_row1);
  assign vert1     = odd_row1 ? reduce2(cfg_method, rp_rdata, pair1)
                              : reduce2(cfg_method, pair1, '0);

  // slice-A buffer: slice A writes, slice B reads
  always_ff @(posedge clk) begin
    if (en && v1 && has_vert1 && !phase1) begin
      sa_mem[idx1] <= vert1;
    end
    if (en) begin
      sa_rdata <= sa_mem[idx1];
    end
  end

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      has_vert2 <= has_vert1;
      phase2    <= phase1;
      last2     <= last1;
      vert2     <= vert1;
    end
  end

  assign res2     = reduce2(cfg_method, sa_rdata, vert2);
  assign out_mask = cfg_wide ? '1 : VOXEL_BITS'((1 << vspd_pkg::NARROW_BITS) - 1);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en && s2_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s2_result) begin
      reduced_voxel <= res2[VOXEL_BITS-1:0] & out_mask;
      last_of_slice <= last2;
    end
  end

endmodule

`default_nettype wire
